/* hdl/lfu_pkg.sv */
// Shared types and constants for the LFU key-value store.
// Used by lfu_cache_with_lru_tiebreak and lfu_checker; no dependencies.
package lfu_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int USES_W      = 32;
    localparam int TOUCH_W     = 64;
    localparam int CFG_W       = 5;
    localparam int CAP_RESET   = 16;
    localparam int S_DATA_W    = KEY_W + VAL_W;
    localparam int M_DATA_W    = VAL_W + KEY_W;
    localparam int S_USER_W    = 1;
    localparam int M_USER_W    = 2;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // One stored entry, one memory word
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [USES_W-1:0]  uses;
        logic [TOUCH_W-1:0] last_touch;
    } entry_t;

endpackage

/* hdl/lfu_cache_with_lru_tiebreak.sv */
// LFU key-value store with least-recently-touched tie break, top level.
// Depends on lfu_pkg; entries live in one single-port-read memory.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser[0] is the command (0 get,
//   1 put), s_tdata[31:0] the key, s_tdata[63:32] the value. Each request
//   yields exactly one result on the m_ channel: m_tuser[0] hit,
//   m_tuser[1] evicted, m_tdata[31:0] read value, m_tdata[63:32] evicted key.
//   The user must write the capacity register via cfg_wr_en / cfg_wr_data only
//   while the block is idle (not enforced); values clamp to 1..ENTRIES.
// Timing:
//   After its request transfer, a result passes a scan over all entries (one
//   entry read per cycle, registered read), a drain step for the last read,
//   and a write-back step that also loads the result register. One request is
//   in work at a time; the next one is taken in the cycle after the result is
//   loaded.
// Reset: a clearing pass over all ENTRIES entries marks every entry invalid;
//   s_tready stays low during it.
// Stall: with m_tready low the result register holds, and a finished request
//   waits in its write-back step until the register frees up.
module lfu_cache_with_lru_tiebreak #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lfu_pkg::S_DATA_W-1:0] s_tdata,   // key[31:0], value[63:32]
    input  logic [lfu_pkg::S_USER_W-1:0] s_tuser,   // cmd[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lfu_pkg::M_DATA_W-1:0] m_tdata,   // read_value[31:0], evicted_key[63:32]
    output logic [lfu_pkg::M_USER_W-1:0] m_tuser    // hit[0], evicted[1]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lfu_pkg::CFG_W) ? CNT_W : lfu_pkg::CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t state_reg;

    lfu_pkg::entry_t mem [ENTRIES];
    lfu_pkg::entry_t rd_data_reg;

    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_pend_reg;

    logic                        cmd_reg;
    logic [lfu_pkg::KEY_W-1:0]   key_reg;
    logic [lfu_pkg::VAL_W-1:0]   value_reg;

    logic [lfu_pkg::CFG_W-1:0]   capacity_reg;
    logic [lfu_pkg::TOUCH_W-1:0] touch_clock_reg;

    // scan results
    logic                        found_reg;
    logic [IDX_W-1:0]            found_idx_reg;
    logic [lfu_pkg::VAL_W-1:0]   found_value_reg;
    logic [lfu_pkg::USES_W-1:0]  found_uses_reg;
    logic                        vic_ok_reg;
    logic [IDX_W-1:0]            vic_idx_reg;
    logic [lfu_pkg::KEY_W-1:0]   vic_key_reg;
    logic [lfu_pkg::USES_W-1:0]  vic_uses_reg;
    logic [lfu_pkg::TOUCH_W-1:0] vic_last_reg;
    logic                        free_ok_reg;
    logic [IDX_W-1:0]            free_idx_reg;
    logic [CNT_W-1:0]            used_reg;

    // result register
    logic                        m_valid_reg;
    logic                        hit_reg;
    logic                        evicted_reg;
    logic [lfu_pkg::VAL_W-1:0]   read_value_reg;
    logic [lfu_pkg::KEY_W-1:0]   evicted_key_reg;

    // memory write port
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    lfu_pkg::entry_t             mem_wdata;

    logic                        out_free;
    logic                        s_fire;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            cap_eff;
    logic                        need_evict;
    logic                        vic_take;
    logic [lfu_pkg::TOUCH_W-1:0] touch_next;
    logic [lfu_pkg::USES_W-1:0]  uses_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {evicted_key_reg, read_value_reg};
    assign m_tuser  = {evicted_reg, hit_reg};

    assign cap_ext = CMP_W'(capacity_reg);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign need_evict = (CMP_W'(used_reg) >= cap_eff) || !free_ok_reg;
    assign touch_next = touch_clock_reg + lfu_pkg::TOUCH_W'(1);
    assign uses_inc   = (found_uses_reg == '1) ? found_uses_reg
                                               : found_uses_reg + lfu_pkg::USES_W'(1);

    // Victim update for the entry returning from memory: lowest count,
    // then oldest touch; the first valid entry seeds it.
    assign vic_take = !vic_ok_reg
                   || (rd_data_reg.uses < vic_uses_reg)
                   || ((rd_data_reg.uses == vic_uses_reg)
                       && (rd_data_reg.last_touch < vic_last_reg));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg;
                mem_wdata = '0;
            end
            ST_RESP: begin
                if (out_free) begin
                    if (found_reg) begin
                        mem_we               = 1'b1;
                        mem_waddr            = found_idx_reg;
                        mem_wdata.valid      = 1'b1;
                        mem_wdata.key        = key_reg;
                        mem_wdata.value      = (cmd_reg == lfu_pkg::CMD_PUT) ? value_reg
                                                                             : found_value_reg;
                        mem_wdata.uses       = uses_inc;
                        mem_wdata.last_touch = touch_next;
                    end else if (cmd_reg == lfu_pkg::CMD_PUT) begin
                        mem_we               = 1'b1;
                        mem_waddr            = need_evict ? vic_idx_reg : free_idx_reg;
                        mem_wdata.valid      = 1'b1;
                        mem_wdata.key        = key_reg;
                        mem_wdata.value      = value_reg;
                        mem_wdata.uses       = lfu_pkg::USES_W'(1);
                        mem_wdata.last_touch = touch_next;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            rd_addr_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            capacity_reg    <= lfu_pkg::CFG_W'(lfu_pkg::CAP_RESET);
            touch_clock_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_RESP) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // fold in the entry read last cycle
            if (rd_pend_reg) begin
                if (rd_data_reg.valid) begin
                    used_reg <= used_reg + CNT_W'(1);
                    if (rd_data_reg.key == key_reg) begin
                        found_reg       <= 1'b1;
                        found_idx_reg   <= rd_idx_reg;
                        found_value_reg <= rd_data_reg.value;
                        found_uses_reg  <= rd_data_reg.uses;
                    end
                    if (vic_take) begin
                        vic_ok_reg   <= 1'b1;
                        vic_idx_reg  <= rd_idx_reg;
                        vic_key_reg  <= rd_data_reg.key;
                        vic_uses_reg <= rd_data_reg.uses;
                        vic_last_reg <= rd_data_reg.last_touch;
                    end
                end else if (!free_ok_reg) begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (rd_addr_reg == LAST_IDX) begin
                        rd_addr_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end else begin
                        rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        cmd_reg     <= s_tuser[0];
                        key_reg     <= s_tdata[lfu_pkg::KEY_W-1:0];
                        value_reg   <= s_tdata[lfu_pkg::S_DATA_W-1:lfu_pkg::KEY_W];
                        found_reg   <= 1'b0;
                        vic_ok_reg  <= 1'b0;
                        free_ok_reg <= 1'b0;
                        used_reg    <= '0;
                        rd_addr_reg <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= rd_addr_reg;
                    if (rd_addr_reg == LAST_IDX) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    rd_pend_reg <= 1'b0;
                    state_reg   <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        hit_reg <= found_reg;
                        if (cmd_reg == lfu_pkg::CMD_GET) begin
                            read_value_reg  <= found_reg ? found_value_reg : '1;
                            evicted_reg     <= 1'b0;
                            evicted_key_reg <= '0;
                            if (found_reg) begin
                                touch_clock_reg <= touch_next;
                            end
                        end else begin
                            read_value_reg  <= '0;
                            touch_clock_reg <= touch_next;
                            evicted_reg     <= !found_reg && need_evict;
                            evicted_key_reg <= (!found_reg && need_evict) ? vic_key_reg : '0;
                        end
                        rd_addr_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/lfu_checker.sv */
// Port-level checks for the LFU key-value store, bound to the top level.
// Depends on lfu_pkg for port widths.
module lfu_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lfu_pkg::M_DATA_W-1:0] m_tdata,
    input logic [lfu_pkg::M_USER_W-1:0] m_tuser
);

    // result holds until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // clearing pass keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open during clearing pass");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    // eviction only on a miss, and evicted key is zero otherwise
    a_evict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1] ? !m_tuser[0]
                                 : (m_tdata[lfu_pkg::M_DATA_W-1:lfu_pkg::VAL_W] == '0)))
        else $error("evicted flag and evicted key disagree");

endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_lfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
